// File: rtl/blzd_pkg.sv
// Shared types and constants for the backward LZ77 decompressor.
// No dependencies; the datapath, controller and top-level files refer to this package by scoped names.
package blzd_pkg;

	localparam int WINDOW_DEPTH = 8192;
	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int DIST_W = 13;
	localparam int LEN_W = 5;
	localparam int FLAGS_PER_BYTE = 8;
	localparam logic [7:0] FLAG_MSB = 8'h80;
	localparam logic [7:0] LEN_SHIFT_MASK = 8'h0F;
	localparam int MIN_MATCH = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_lit;
		logic is_match;
		logic out_free;
		logic token_last;
	} ctrl_status_t;

endpackage

// File: rtl/blzd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module blzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/blzd_datapath.sv
// Datapath: token parsing registers, history ring, copy counter and output register.
// Depends on blzd_pkg and blzd_ram.
module blzd_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  blzd_pkg::ctrl_cmd_t      cmd,
	output blzd_pkg::ctrl_status_t   status,
	input  blzd_pkg::in_item_t       in_item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output blzd_pkg::out_item_t      out_item
);

	typedef enum logic [1:0] {
		PH_FLAG  = 2'd0,
		PH_FIRST = 2'd1,
		PH_PAIR  = 2'd2
	} phase_t;

	localparam logic [blzd_pkg::PTR_W:0] DEPTH_EXT = (blzd_pkg::PTR_W + 1)'(blzd_pkg::WINDOW_DEPTH);
	localparam logic [blzd_pkg::CNT_W-1:0] CNT_MAX = blzd_pkg::CNT_W'(blzd_pkg::WINDOW_DEPTH);
	localparam logic [blzd_pkg::PTR_W-1:0] PTR_LAST = blzd_pkg::PTR_W'(blzd_pkg::WINDOW_DEPTH - 1);

	phase_t                      phase_q;
	logic [7:0]                  flag_bits_q;
	logic [3:0]                  flags_left_q;
	logic [7:0]                  pair_first_q;
	logic                        pending_end_q;
	logic [blzd_pkg::PTR_W-1:0]  wp_q;
	logic [blzd_pkg::CNT_W-1:0]  produced_q;
	logic [blzd_pkg::LEN_W-1:0]  count_q;
	logic                        lit_mode_q;
	logic [7:0]                  lit_q;
	logic [blzd_pkg::DIST_W-1:0] dist_q;
	logic                        out_valid_q;
	blzd_pkg::out_item_t         out_q;

	logic                        flag_set;
	logic [blzd_pkg::PTR_W:0]    wp_ext;
	logic [blzd_pkg::PTR_W:0]    dist_ext;
	logic [blzd_pkg::PTR_W-1:0]  rd_addr;
	logic [7:0]                  ram_rdata;
	logic                        too_far;
	logic [7:0]                  emit_byte;
	logic [3:0]                  flags_next;

	assign flag_set = (flag_bits_q & blzd_pkg::FLAG_MSB) != 8'h00;
	assign wp_ext = {1'b0, wp_q};
	assign dist_ext = (blzd_pkg::PTR_W + 1)'(dist_q);
	assign rd_addr = blzd_pkg::PTR_W'((wp_ext >= dist_ext) ? (wp_ext - dist_ext)
		: (wp_ext + DEPTH_EXT - dist_ext));
	assign too_far = blzd_pkg::CNT_W'(dist_q) > produced_q;
	assign emit_byte = lit_mode_q ? lit_q : (too_far ? 8'h00 : ram_rdata);
	assign flags_next = (flags_left_q != 4'd0) ? flags_left_q - 4'd1 : 4'd0;

	assign status.is_lit = (phase_q == PH_FIRST) && !flag_set;
	assign status.is_match = (phase_q == PH_PAIR);
	assign status.out_free = !out_valid_q || out_ready;
	assign status.token_last = (count_q == blzd_pkg::LEN_W'(1));

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	blzd_ram #(
		.WIDTH(8),
		.DEPTH(blzd_pkg::WINDOW_DEPTH)
	) u_history (
		.clk  (clk),
		.we   (cmd.emit),
		.waddr(wp_q),
		.wdata(emit_byte),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			flag_bits_q <= 8'h00;
			flags_left_q <= 4'd0;
			pair_first_q <= 8'h00;
			pending_end_q <= 1'b0;
			wp_q <= '0;
			produced_q <= '0;
			count_q <= '0;
			lit_mode_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.accept) begin
				if (in_item.last_in) begin
					pending_end_q <= 1'b1;
				end
				unique case (phase_q)
					PH_FIRST: begin
						if (flag_set) begin
							pair_first_q <= in_item.in_byte;
							phase_q <= PH_PAIR;
						end else begin
							lit_mode_q <= 1'b1;
							count_q <= blzd_pkg::LEN_W'(1);
						end
					end
					PH_PAIR: begin
						lit_mode_q <= 1'b0;
						count_q <= blzd_pkg::LEN_W'(pair_first_q[7:4])
							+ blzd_pkg::LEN_W'(blzd_pkg::MIN_MATCH);
					end
					default: begin
						flag_bits_q <= in_item.in_byte;
						flags_left_q <= 4'(blzd_pkg::FLAGS_PER_BYTE);
						phase_q <= PH_FIRST;
					end
				endcase
			end
			if (cmd.emit) begin
				count_q <= count_q - blzd_pkg::LEN_W'(1);
				if (status.token_last && pending_end_q) begin
					phase_q <= PH_FLAG;
					flag_bits_q <= 8'h00;
					flags_left_q <= 4'd0;
					pair_first_q <= 8'h00;
					pending_end_q <= 1'b0;
					wp_q <= '0;
					produced_q <= '0;
				end else begin
					wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + blzd_pkg::PTR_W'(1);
					if (produced_q != CNT_MAX) begin
						produced_q <= produced_q + blzd_pkg::CNT_W'(1);
					end
					if (status.token_last) begin
						flag_bits_q <= {flag_bits_q[6:0], 1'b0};
						flags_left_q <= flags_next;
						phase_q <= (flags_next == 4'd0) ? PH_FLAG : PH_FIRST;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lit_q <= in_item.in_byte;
			dist_q <= blzd_pkg::DIST_W'({pair_first_q & blzd_pkg::LEN_SHIFT_MASK, in_item.in_byte})
				+ blzd_pkg::DIST_W'(blzd_pkg::MIN_MATCH);
		end
		if (cmd.emit) begin
			out_q.out_byte <= emit_byte;
			out_q.run_last <= status.token_last;
			out_q.frame_end <= status.token_last && pending_end_q;
		end
	end

endmodule

// File: rtl/blzd_ctrl.sv
// Controller: sequences input acceptance, history reads and result emission.
// Depends on blzd_pkg.
module blzd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  blzd_pkg::ctrl_status_t status,
	output blzd_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_INPUT,
		S_READ,
		S_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_INPUT);
	assign cmd.accept = in_valid && (state_q == S_INPUT);
	assign cmd.rd_en = (state_q == S_READ);
	assign cmd.emit = (state_q == S_EMIT) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INPUT;
		end else begin
			unique case (state_q)
				S_INPUT: begin
					if (in_valid) begin
						if (status.is_match) begin
							state_q <= S_READ;
						end else if (status.is_lit) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (status.out_free) begin
						state_q <= status.token_last ? S_INPUT : S_READ;
					end
				end
				default: begin
					state_q <= S_INPUT;
				end
			endcase
		end
	end

endmodule

// File: rtl/backward_lz77_decompressor.sv
// Backward LZ77 decompressor. A flag byte or a match's first byte is only accepted;
// a literal is accepted and then emitted; a match of n bytes is accepted and then takes
// one registered history read and one emit per byte.
// Results sit in an output register, so the next item is taken while one waits.
// Asynchronous reset clears all control state; the history needs no clearing pass.
module backward_lz77_decompressor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  blzd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output blzd_pkg::out_item_t out_item
);

	blzd_pkg::ctrl_cmd_t    cmd;
	blzd_pkg::ctrl_status_t status;

	blzd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	blzd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule
